FILE: rtl/core/sha1_pkg.sv
package sha1_pkg;

   // Sizes of the byte stream, block and digest
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int BYTE_W          = 8;
   localparam int WORD_W          = 32;
   localparam int DIGEST_WORDS    = 5;
   localparam int IDX_W           = 3;
   localparam int FILL_W          = 6;
   localparam int LEN_W           = 64;
   localparam int BLOCK_WORDS     = 16;
   localparam int BLOCK_BITS      = BLOCK_WORDS * WORD_W;

   // Padding constants
   localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
   localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
   localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
   localparam logic [IDX_W-1:0]  LAST_WORD = 3'd4;

   // One input item as it sits in the queue
   typedef struct packed {
      logic                has_byte;
      logic [BYTE_W-1:0]   data_byte;
      logic                end_of_message;
   } sha1_item_type;

   // Commands from the packer to the round engine
   typedef struct packed {
      logic start;
      logic restart;
   } sha1_ctl_type;

   // Status from the round engine
   typedef struct packed {
      logic busy;
   } sha1_stat_type;

   typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] sha1_chain_type;
   typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]  sha1_block_type;

endpackage

FILE: rtl/core/sha1_hash.sv
// Items pass through the queue into the packer, which holds them back only while a
// full 64-byte block waits for the round engine or a message end is padded and sent.
// A block holds the round engine for 80 rounds and one chaining add. Bytes of the
// next block fill the packer while the rounds run; its last byte waits for the engine.
// Message end: padding adds pad bytes that close one or two blocks, then the packer
// sends five digest words. Synchronous reset restores the initial chaining words.
module sha1_hash #(
   parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sha1_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic                          req_tuser,   // [0] has_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sha1_pkg::WORD_W-1:0]   rsp_tdata,   // [31:0] digest_word
   output logic [sha1_pkg::IDX_W-1:0]    rsp_tuser,   // [2:0] word_index
   output logic                          rsp_tlast
);
   import sha1_pkg::*;

   sha1_item_type  in_item, q_item;
   logic           q_valid, q_ready;
   sha1_ctl_type   ctl;
   sha1_stat_type  stat;
   sha1_chain_type chain;
   sha1_block_type blk;

   // Classify the transfer into an item
   assign in_item.has_byte       = req_tuser;
   assign in_item.data_byte      = req_tdata;
   assign in_item.end_of_message = req_tlast;

   sha1_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (in_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   sha1_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .stat       (stat),
      .chain      (chain),
      .ctl        (ctl),
      .blk        (blk),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_round u_round (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .blk   (blk),
      .stat  (stat),
      .chain (chain)
   );

endmodule

FILE: rtl/core/sha1_fifo.sv
module sha1_fifo #(
   parameter int DEPTH = sha1_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  sha1_pkg::sha1_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output sha1_pkg::sha1_item_type pop_item
);
   import sha1_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sha1_item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   push, pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

FILE: rtl/core/sha1_round.sv
module sha1_round (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1_pkg::sha1_ctl_type   ctl,
   input  sha1_pkg::sha1_block_type blk,
   output sha1_pkg::sha1_stat_type  stat,
   output sha1_pkg::sha1_chain_type chain
);
   import sha1_pkg::*;

   localparam logic [6:0] R_SCHED = 7'd16;
   localparam logic [6:0] R_40    = 7'd40;
   localparam logic [6:0] R_20    = 7'd20;
   localparam logic [6:0] R_60    = 7'd60;
   localparam logic [6:0] R_ADD   = 7'd80;

   localparam sha1_chain_type H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   sha1_chain_type     chain_ff, chain_in;
   sha1_chain_type     wv_ff, wv_in;
   sha1_block_type     wd_ff, wd_in;
   logic [6:0]         rnd_ff, rnd_in;
   logic               busy_ff, busy_in;
   logic [WORD_W-1:0]  sched_w, cur_w, fn, kc, tmp;

   function automatic logic [WORD_W-1:0] round_f(input logic [6:0] r,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      if (r < R_20) begin
         return (b & c) | (~b & d);
      end else if (r < R_40) begin
         return b ^ c ^ d;
      end else if (r < R_60) begin
         return (b & c) | (b & d) | (c & d);
      end
      return b ^ c ^ d;
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input logic [6:0] r);
      if (r < R_20) begin
         return 32'h5A827999;
      end else if (r < R_40) begin
         return 32'h6ED9EBA1;
      end else if (r < R_60) begin
         return 32'h8F1BBCDC;
      end
      return 32'hCA62C1D6;
   endfunction

   assign stat.busy = busy_ff;
   assign chain     = chain_ff;

   // Oldest schedule word sits in the top slot; taps are fixed
   assign sched_w = wd_ff[15] ^ wd_ff[13] ^ wd_ff[7] ^ wd_ff[2];
   assign cur_w   = (rnd_ff < R_SCHED) ? wd_ff[15] : {sched_w[30:0], sched_w[31]};
   assign fn      = round_f(rnd_ff, wv_ff[1], wv_ff[2], wv_ff[3]);
   assign kc      = round_k(rnd_ff);
   assign tmp     = {wv_ff[0][26:0], wv_ff[0][31:27]} + fn + wv_ff[4] + cur_w + kc;

   // Load a block, run the rounds, then fold into the chaining words
   always_comb begin
      chain_in = chain_ff;
      wv_in    = wv_ff;
      wd_in    = wd_ff;
      rnd_in   = rnd_ff;
      busy_in  = busy_ff;
      if (ctl.restart) begin
         chain_in = H_INIT;
      end
      if (ctl.start) begin
         wd_in   = blk;
         wv_in   = chain_ff;
         rnd_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rnd_ff == R_ADD) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + wv_ff[i];
            end
            rnd_in  = '0;
            busy_in = 1'b0;
         end else begin
            wv_in[4] = wv_ff[3];
            wv_in[3] = wv_ff[2];
            wv_in[2] = {wv_ff[1][1:0], wv_ff[1][31:2]};
            wv_in[1] = wv_ff[0];
            wv_in[0] = tmp;
            wd_in    = {wd_ff[14:0], cur_w};
            rnd_in   = rnd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= H_INIT;
         rnd_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         rnd_ff   <= rnd_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      wv_ff <= wv_in;
      wd_ff <= wd_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("block handed over while rounds run");

   a_restart_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.restart |-> !busy_ff && !ctl.start)
      else $error("chaining restart during a block");

   a_add_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rnd_ff == R_ADD && !ctl.start |=> !busy_ff)
      else $error("engine still busy after the chaining add");

endmodule

FILE: rtl/core/sha1_pack.sv
module sha1_pack (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   output logic                               item_ready,
   input  sha1_pkg::sha1_item_type            item,
   input  sha1_pkg::sha1_stat_type            stat,
   input  sha1_pkg::sha1_chain_type           chain,
   output sha1_pkg::sha1_ctl_type             ctl,
   output sha1_pkg::sha1_block_type           blk,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sha1_pkg::WORD_W-1:0]        rsp_tdata,
   output logic [sha1_pkg::IDX_W-1:0]         rsp_tuser,
   output logic                               rsp_tlast
);
   import sha1_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PAD   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } pack_state_type;

   pack_state_type         state_ff, state_in;
   logic [BLOCK_BITS-1:0]  blk_ff, blk_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   mark_ff, mark_in;
   logic [2:0]             len_cnt_ff, len_cnt_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   can_put, out_free, put;
   logic [BYTE_W-1:0]      put_byte;

   // A full block can only go out when the engine is free
   assign can_put  = !(fill_ff == FILL_LAST && stat.busy);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign blk      = {blk_ff[BLOCK_BITS-BYTE_W-1:0], put_byte};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Absorb bytes, pad the message end, then send the digest
   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      mark_in      = mark_ff;
      len_cnt_in   = len_cnt_ff;
      widx_in      = widx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      item_ready   = 1'b0;
      put          = 1'b0;
      put_byte     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            item_ready = can_put;
            if (item_valid && can_put) begin
               if (item.has_byte) begin
                  put      = 1'b1;
                  put_byte = item.data_byte;
                  len_in   = len_ff + LEN_W'(8);
               end
               if (item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (can_put) begin
               put = 1'b1;
               if (!mark_ff) begin
                  put_byte = PAD_MARK;
                  mark_in  = 1'b1;
               end else if (len_cnt_ff != '0 || fill_ff == FILL_LEN) begin
                  put_byte   = len_ff[LEN_W-1 -: BYTE_W];
                  len_in     = {len_ff[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                  len_cnt_in = len_cnt_ff + 1'b1;
                  if (len_cnt_ff == 3'd7) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  put_byte = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = ST_OUT;
               widx_in  = '0;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = chain[widx_ff];
               rsp_idx_in   = widx_ff;
               rsp_last_in  = (widx_ff == LAST_WORD);
               widx_in      = widx_ff + 1'b1;
               if (widx_ff == LAST_WORD) begin
                  ctl.restart = 1'b1;
                  len_in      = '0;
                  mark_in     = 1'b0;
                  len_cnt_in  = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Shift the byte in; hand over the block on the last byte
      if (put) begin
         blk_in  = blk;
         fill_in = fill_ff + 1'b1;
         if (fill_ff == FILL_LAST) begin
            ctl.start = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         mark_ff      <= 1'b0;
         len_cnt_ff   <= '0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         mark_ff      <= mark_in;
         len_cnt_ff   <= len_cnt_in;
         widx_ff      <= widx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_out_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> !stat.busy && fill_ff == '0)
      else $error("digest read while a block is still open");

endmodule

FILE: test/sha1_digest_checker.sv
module sha1_digest_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [sha1_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic                          req_tuser,   // [0] has_byte
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [sha1_pkg::WORD_W-1:0]   rsp_tdata,   // [31:0] digest_word
   input  logic [sha1_pkg::IDX_W-1:0]    rsp_tuser,   // [2:0] word_index
   input  logic                          rsp_tlast,
   output int unsigned                   fail_count,
   output int unsigned                   pending_words
);
   import sha1_pkg::*;

   localparam sha1_chain_type CHAIN_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };
   localparam logic [WORD_W-1:0] ROUND_K0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] ROUND_K3 = 32'hCA62C1D6;

   typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] word;
      logic              last;
   } digest_word_type;

   // Shadow hash state
   sha1_chain_type     chain_words;
   sha1_block_type     sched_words;
   logic [LEN_W-1:0]   msg_bits;
   logic [FILL_W-1:0]  block_bytes;

   digest_word_type    digest_q[$];
   int unsigned        mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   // Run the 80 rounds over the current block and fold into the chain
   task automatic compress_block();
      logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
      int                s;
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int r = 0; r < 80; r++) begin
         s = r % 16;
         if (r >= 16) begin
            sched_words[s] = rotl(sched_words[(s + 13) % 16] ^ sched_words[(s + 8) % 16]
                                  ^ sched_words[(s + 2) % 16] ^ sched_words[s], 1);
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
         t = rotl(a, 5) + f + e + sched_words[s] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] = chain_words[0] + a;
      chain_words[1] = chain_words[1] + b;
      chain_words[2] = chain_words[2] + c;
      chain_words[3] = chain_words[3] + d;
      chain_words[4] = chain_words[4] + e;
   endtask

   // Pack one byte big-endian into the block; compress when it fills
   task automatic absorb_byte(input logic [BYTE_W-1:0] value);
      int slot;
      slot = int'(block_bytes[FILL_W-1:2]);
      if (block_bytes[1:0] == 2'd0) begin
         sched_words[slot] = {value, 24'h0};
      end else begin
         sched_words[slot][8 * (3 - block_bytes[1:0]) +: 8] = value;
      end
      block_bytes = block_bytes + 1'b1;
      if (block_bytes == '0) begin
         compress_block();
      end
   endtask

   task automatic clear_message();
      chain_words = CHAIN_INIT;
      msg_bits    = '0;
      block_bytes = '0;
   endtask

   // Pad, append the length, queue the five digest words and restart
   task automatic finish_message();
      logic [LEN_W-1:0] len;
      digest_word_type  dw;
      len = msg_bits;
      absorb_byte(PAD_MARK);
      while (block_bytes != FILL_LEN) begin
         absorb_byte('0);
      end
      for (int k = 7; k >= 0; k--) begin
         absorb_byte(len[8 * k +: 8]);
      end
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         dw.idx  = IDX_W'(i);
         dw.word = chain_words[i];
         dw.last = (IDX_W'(i) == LAST_WORD);
         digest_q.insert(digest_q.size(), dw);
      end
      clear_message();
   endtask

   always @(posedge clock) begin
      digest_word_type dw;
      if (reset) begin
         clear_message();
         digest_q.delete();
      end else begin
         // Compare each result transfer with the oldest queued word
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               $error("digest word with none queued: word_index %0d digest_word %08h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               dw = digest_q.pop_front();
               if (rsp_tuser !== dw.idx) begin
                  $error("word_index: expected %0d, got %0d", dw.idx, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== dw.word) begin
                  $error("digest_word: expected %08h, got %08h", dw.word, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== dw.last) begin
                  $error("last_word: expected %0d, got %0d", dw.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         // Advance the shadow hash on each input transfer
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               absorb_byte(req_tdata);
               msg_bits = msg_bits + LEN_W'(8);
            end
            if (req_tlast) begin
               finish_message();
            end
         end
      end
      pending_words <= digest_q.size();
   end

endmodule

FILE: test/tb_sha1_hash.sv
module tb_sha1_hash;
   import sha1_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          SETTLE_CYCLES = 300;
   localparam int          ITEM_COUNT    = 110;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata;
   logic                 req_tuser;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [WORD_W-1:0]    rsp_tdata;
   logic [IDX_W-1:0]     rsp_tuser;
   logic                 rsp_tlast;

   int unsigned          fail_count;
   int unsigned          pending_words;
   int unsigned          cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   items_sent = 0;

   always #5 clock = ~clock;

   sha1_hash u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_digest_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // Stall the result side at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic set_phase(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 51; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 51; end
         default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
      endcase
   endtask

   // Offer one item after a random gap; return once it is transferred
   task automatic send_item(input logic has_byte, input logic [BYTE_W-1:0] value,
                            input logic end_of_msg);
      set_phase(items_sent * 4 / ITEM_COUNT);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= has_byte;
      req_tdata  <= value;
      req_tlast  <= end_of_msg;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Hold the sender until every queued digest word has come out
   task automatic drain_digests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [BYTE_W-1:0] rand_byte();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic int pick_length();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return $urandom_range(8);
      if (pick < 7) return $urandom_range(40, 9);
      case ($urandom_range(7))
         0: return 55;
         1: return 56;
         2: return 57;
         3: return 63;
         4: return 64;
         5: return 65;
         6: return 119;
         default: return 120;
      endcase
   endfunction

   initial begin
      int  msg_len;
      int  body_len;
      bit  end_with_byte;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, short strings, extreme bytes, no-op items
      send_item(1'b0, 8'hA5, 1'b1);
      send_item(1'b0, 8'h00, 1'b0);
      send_item(1'b1, 8'h61, 1'b0);
      send_item(1'b1, 8'h62, 1'b0);
      send_item(1'b1, 8'h63, 1'b1);
      send_item(1'b1, 8'hFF, 1'b1);
      drain_digests();
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b0, 8'hFF, 1'b1);
      send_item(1'b1, 8'hFF, 1'b0);
      send_item(1'b0, 8'h5A, 1'b0);
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b1, 8'hAA, 1'b0);
      send_item(1'b1, 8'h55, 1'b0);
      send_item(1'b1, 8'h80, 1'b1);
      drain_digests();

      // Random messages, with lengths around the padding boundaries
      while (items_sent < ITEM_COUNT) begin
         msg_len = pick_length();
         if (msg_len > ITEM_COUNT - items_sent) begin
            msg_len = ITEM_COUNT - items_sent;
         end
         end_with_byte = (msg_len > 0) && ($urandom_range(1) == 1);
         body_len      = end_with_byte ? msg_len - 1 : msg_len;
         for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(9) == 0) begin
               send_item(1'b0, rand_byte(), 1'b0);
            end
            send_item(1'b1, rand_byte(), 1'b0);
         end
         send_item(end_with_byte, rand_byte(), 1'b1);
         if ($urandom_range(5) == 0) begin
            drain_digests();
         end
      end

      drain_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
